// ----- rtl/core/s2sdm_pkg.sv -----
// Shared types, codes and constants of the surround-to-stereo downmix.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package s2sdm_pkg;

    // Sample encodings selected by the format register.
    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_F32 = 2'd3
    } t_fmt;

    // Configuration register indexes.
    localparam logic CFG_SAMPLE_FORMAT = 1'b0;
    localparam logic CFG_MIX_ENABLE    = 1'b1;

    localparam t_fmt FMT_RESET = FMT_S16;

    typedef struct packed {
        t_fmt fmt;
        logic mix;
    } t_mode;

    // Truncating right shift applied to the scaled value.
    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_PCM_MIX,
        SHIFT_FLT_COPY,
        SHIFT_FLT_MIX
    } t_shift;

    localparam int SHIFT_PCM_MIX_BITS  = 16;
    localparam int SHIFT_FLT_COPY_BITS = 23;
    localparam int SHIFT_FLT_MIX_BITS  = 39;

    // Decoded channel: PCM in 16-bit scale or float in Q1.23, both fit here.
    localparam int CH_W     = 25;
    localparam int PAIR_W   = CH_W + 1;
    localparam int PROD_W   = 42;
    localparam int SCALED_W = 58;
    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 32;
    localparam int NUM_CH   = 6;

    localparam logic signed [15:0] COEF_FB    = 16'sd19195;
    localparam logic signed [15:0] COEF_CL    = 16'sd13573;
    localparam int                 FULL_SHIFT = 15;   // 32767 = 2^15 - 1

    typedef logic signed [CH_W-1:0]   t_ch;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [WORD_W-1:0] front_left;
        logic [WORD_W-1:0] front_right;
        logic [WORD_W-1:0] centre;
        logic [WORD_W-1:0] low_freq;
        logic [WORD_W-1:0] back_left;
        logic [WORD_W-1:0] back_right;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/core/s2sdm_decode.sv -----
// Decodes one raw channel word into a signed value (PCM scale or Q1.23).
// Depends on s2sdm_pkg.
`default_nettype none

module s2sdm_decode
    import s2sdm_pkg::*;
(
    input  wire  [WORD_W-1:0] i_word,
    input  t_fmt              i_fmt,
    output t_ch               o_value
);

    logic [7:0]  exp_f;
    logic [22:0] man_f;
    logic [7:0]  sh_f;
    logic [23:0] mag_f;
    t_ch         flt_value;

    always_comb begin
        exp_f = i_word[30:23];
        man_f = i_word[22:0];
        sh_f  = 8'd127 - exp_f;
        if (exp_f == 8'hFF && man_f != '0) begin
            mag_f = '0;                         // NaN reads as zero
        end else if (exp_f >= 8'd127) begin
            mag_f = 24'h800000;                 // clip to one
        end else if (exp_f == 8'd0 || sh_f >= 8'd24) begin
            mag_f = '0;                         // subnormal or tiny
        end else begin
            mag_f = {1'b1, man_f} >> sh_f[4:0];
        end
        flt_value = i_word[31] ? -$signed({1'b0, mag_f}) : $signed({1'b0, mag_f});
    end

    always_comb begin
        case (i_fmt)
            FMT_U8:  o_value = {{9{~i_word[7]}}, ~i_word[7], i_word[6:0], 8'h00};
            FMT_S16: o_value = {{9{i_word[15]}}, i_word[15:0]};
            FMT_S24: o_value = {{9{i_word[23]}}, i_word[23:8]};
            FMT_F32: o_value = flt_value;
            default: o_value = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/s2sdm_mix.sv -----
// Pair sums and coefficient products of the downmix (front+back, centre+LFE).
// Depends on s2sdm_pkg.
`default_nettype none

module s2sdm_mix
    import s2sdm_pkg::*;
(
    input  t_ch   i_fl,
    input  t_ch   i_fr,
    input  t_ch   i_c,
    input  t_ch   i_lfe,
    input  t_ch   i_bl,
    input  t_ch   i_br,
    output t_prod o_prod_l,
    output t_prod o_prod_r,
    output t_prod o_prod_c
);

    logic signed [PAIR_W-1:0] sum_l;
    logic signed [PAIR_W-1:0] sum_r;
    logic signed [PAIR_W-1:0] sum_c;

    always_comb begin
        sum_l    = PAIR_W'(i_fl) + PAIR_W'(i_bl);
        sum_r    = PAIR_W'(i_fr) + PAIR_W'(i_br);
        sum_c    = PAIR_W'(i_c) + PAIR_W'(i_lfe);
        o_prod_l = sum_l * COEF_FB;
        o_prod_r = sum_r * COEF_FB;
        o_prod_c = sum_c * COEF_CL;
    end

endmodule

`default_nettype wire

// ----- rtl/core/s2sdm_scale.sv -----
// Final scaling of one side: float full-scale multiply, then truncating shift.
// Depends on s2sdm_pkg.
`default_nettype none

module s2sdm_scale
    import s2sdm_pkg::*;
(
    input  t_prod                       i_num,
    input  t_mode                       i_mode,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    t_shift                     shift;
    logic [5:0]                 sh;
    logic signed [SCALED_W-1:0] ext;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SCALED_W-1:0] biased;
    logic signed [SCALED_W-1:0] quot;
    logic [SCALED_W-1:0]        bias;

    always_comb begin
        if (i_mode.mix) begin
            shift = (i_mode.fmt == FMT_F32) ? SHIFT_FLT_MIX : SHIFT_PCM_MIX;
        end else begin
            shift = (i_mode.fmt == FMT_F32) ? SHIFT_FLT_COPY : SHIFT_NONE;
        end

        case (shift)
            SHIFT_NONE:     sh = '0;
            SHIFT_PCM_MIX:  sh = 6'(SHIFT_PCM_MIX_BITS);
            SHIFT_FLT_COPY: sh = 6'(SHIFT_FLT_COPY_BITS);
            SHIFT_FLT_MIX:  sh = 6'(SHIFT_FLT_MIX_BITS);
            default:        sh = '0;
        endcase

        // times 32767 as a shift and subtract
        ext = SCALED_W'(i_num);
        if (i_mode.fmt == FMT_F32) begin
            scaled = (ext <<< FULL_SHIFT) - ext;
        end else begin
            scaled = ext;
        end

        // round toward zero: bias negatives by 2^sh - 1 before shifting
        bias     = scaled[SCALED_W-1] ? ((SCALED_W'(1) << sh) - SCALED_W'(1)) : '0;
        biased   = scaled + $signed(bias);
        quot     = biased >>> sh;
        o_sample = quot[SAMPLE_W-1:0];
    end

endmodule

`default_nettype wire

// ----- rtl/core/surround_to_stereo_downmix.sv -----
// Surround (5.1) to stereo downmix: six raw channel words in, one stereo pair out.
// Result is registered through four register stages;
// throughput 1 item per cycle, input stalls only while a full pipeline sees output stall.
// Pipeline: input register, decode + coefficient products, side sums, final scale.
// Reset (synchronous, active low) empties the pipeline, sets format to signed
// 16-bit and clears mix enable. Depends on s2sdm_pkg and the s2sdm_* modules.
`default_nettype none

module surround_to_stereo_downmix
    import s2sdm_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,

    // input item channel
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,

    // result item channel
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_item  o_out_item,

    // configuration write channel
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire  [1:0] i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers: always ready; the user is to write them only while idle (the block does not enforce it).
    // ---------------------------------------------------------------
    t_fmt r_fmt;
    logic r_mix;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RESET;
            r_mix <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SAMPLE_FORMAT: r_fmt <= t_fmt'(i_cfg_data);
                CFG_MIX_ENABLE:    r_mix <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or the
    // stage after it advances. An output stall holds the last stage and each full stage behind it.
    // ---------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !r4_valid || !i_out_stall;
    assign adv3 = !r3_valid || adv4;
    assign adv2 = !r2_valid || adv3;
    assign adv1 = !r1_valid || adv2;

    assign o_in_stall  = !adv1;
    assign o_out_valid = r4_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (adv1) r1_valid <= i_in_valid;
            if (adv2) r2_valid <= r1_valid;
            if (adv3) r3_valid <= r2_valid;
            if (adv4) r4_valid <= r3_valid;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: capture the raw item.
    // ---------------------------------------------------------------
    t_in_item r1_item;

    always_ff @(posedge i_clk) begin
        if (adv1 && i_in_valid) begin
            r1_item <= i_in_item;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: decode all six channels, form pair sums and products.
    // ---------------------------------------------------------------
    t_ch   ch_fl, ch_fr, ch_c, ch_lfe, ch_bl, ch_br;
    t_prod n_prod_l, n_prod_r, n_prod_c;

    s2sdm_decode u_dec_fl  (.i_word(r1_item.front_left),  .i_fmt(r_fmt), .o_value(ch_fl));
    s2sdm_decode u_dec_fr  (.i_word(r1_item.front_right), .i_fmt(r_fmt), .o_value(ch_fr));
    s2sdm_decode u_dec_c   (.i_word(r1_item.centre),      .i_fmt(r_fmt), .o_value(ch_c));
    s2sdm_decode u_dec_lfe (.i_word(r1_item.low_freq),    .i_fmt(r_fmt), .o_value(ch_lfe));
    s2sdm_decode u_dec_bl  (.i_word(r1_item.back_left),   .i_fmt(r_fmt), .o_value(ch_bl));
    s2sdm_decode u_dec_br  (.i_word(r1_item.back_right),  .i_fmt(r_fmt), .o_value(ch_br));

    s2sdm_mix u_mix (
        .i_fl     (ch_fl),
        .i_fr     (ch_fr),
        .i_c      (ch_c),
        .i_lfe    (ch_lfe),
        .i_bl     (ch_bl),
        .i_br     (ch_br),
        .o_prod_l (n_prod_l),
        .o_prod_r (n_prod_r),
        .o_prod_c (n_prod_c)
    );

    t_prod r2_prod_l, r2_prod_r, r2_prod_c;
    t_ch   r2_ch_l, r2_ch_r;
    t_mode r2_mode;

    always_ff @(posedge i_clk) begin
        if (adv2 && r1_valid) begin
            r2_prod_l <= n_prod_l;
            r2_prod_r <= n_prod_r;
            r2_prod_c <= n_prod_c;
            r2_ch_l   <= ch_fl;
            r2_ch_r   <= ch_fr;
            r2_mode   <= '{fmt: r_fmt, mix: r_mix};
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: pick the value to scale per side. Mixing adds the shared
    // centre/LFE term; 8-bit with mixing gives silence; copy passes the
    // front channels.
    // ---------------------------------------------------------------
    t_prod n_num_l, n_num_r;
    t_prod r3_num_l, r3_num_r;
    t_mode r3_mode;

    always_comb begin
        if (r2_mode.mix) begin
            if (r2_mode.fmt == FMT_U8) begin
                n_num_l = '0;
                n_num_r = '0;
            end else begin
                n_num_l = r2_prod_l + r2_prod_c;
                n_num_r = r2_prod_r + r2_prod_c;
            end
        end else begin
            n_num_l = PROD_W'(r2_ch_l);
            n_num_r = PROD_W'(r2_ch_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r2_valid) begin
            r3_num_l <= n_num_l;
            r3_num_r <= n_num_r;
            r3_mode  <= r2_mode;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: full-scale multiply for float, truncating shift, result
    // register. The result always fits 16 bits.
    // ---------------------------------------------------------------
    t_out_item n_out;

    s2sdm_scale u_scale_l (.i_num(r3_num_l), .i_mode(r3_mode), .o_sample(n_out.left_out));
    s2sdm_scale u_scale_r (.i_num(r3_num_r), .i_mode(r3_mode), .o_sample(n_out.right_out));

    t_out_item r4_item;

    always_ff @(posedge i_clk) begin
        if (adv4 && r3_valid) begin
            r4_item <= n_out;
        end
    end

    assign o_out_item = r4_item;

endmodule

`default_nettype wire

// ----- tb/sv/surround_to_stereo_downmix_tb.sv -----
// Self-checking testbench for surround_to_stereo_downmix: directed and random frames
// checked against a built-in downmix predictor. Depends on s2sdm_pkg and the RTL top.
`default_nettype none

module surround_to_stereo_downmix_tb;
    import s2sdm_pkg::*;

    // Predictor constants: Q0.16 coefficients, float full scale and divisors.
    localparam longint MIX_FRONT_BACK = 19195;
    localparam longint MIX_CENTRE_LFE = 13573;
    localparam longint FLT_FULL_SCALE = 32767;
    localparam longint Q23_UNIT       = 64'sd8388608;
    localparam longint PCM_MIX_DIV    = 64'sd65536;
    localparam longint FLT_MIX_DIV    = 64'sd549755813888;   // 2^39

    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;        // pipeline latency plus margin
    localparam int TIMEOUT       = 1600000;  // watchdog limit, in simulation time units

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_index = 1'b0;
    logic [1:0] cfg_data  = 2'b00;

    logic       in_stall;
    logic       out_valid;
    t_out_item  out_item;
    logic       cfg_ready;

    // Shadow of the block's registers, as of the last accepted write.
    t_fmt       mode_fmt = FMT_S16;
    logic       mode_mix = 1'b0;

    t_in_item   frames_q[$];     // frames waiting to be offered
    t_out_item  stereo_q[$];     // predicted stereo pairs, oldest first

    logic       in_taken      = 1'b0;
    int         mismatches    = 0;
    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    logic       long_hold     = 1'b0;
    int         hold_count    = 0;

    surround_to_stereo_downmix u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Decode one raw channel word: PCM to 16-bit scale, float to Q1.23.
    function automatic longint decode_word(input logic [31:0] w, input t_fmt fmt);
        logic [7:0]  e;
        logic [22:0] m;
        longint      mag;
        int          sh;
        case (fmt)
            FMT_U8:  return (longint'(w[7:0]) - 128) * 256;
            FMT_S16: return longint'($signed(w[15:0]));
            FMT_S24: return longint'($signed(w[23:8]));
            default: begin
                e = w[30:23];
                m = w[22:0];
                // NaN reads as zero; infinity and anything of magnitude >= 1 clips.
                if (e == 8'hFF && m != 0)
                    return 0;
                if (e >= 8'd127) begin
                    mag = Q23_UNIT;
                end else if (e == 8'd0) begin
                    mag = 0;
                end else begin
                    sh  = 127 - int'(e);
                    mag = (sh >= 24) ? 0 : (longint'({1'b1, m}) >> sh);
                end
                return w[31] ? -mag : mag;
            end
        endcase
    endfunction

    // Expected stereo pair for one frame under the given mode.
    function automatic t_out_item downmix_pair(input t_in_item it, input t_fmt fmt,
                                               input logic mix);
        longint    fl, fr, ce, lfe, bl, br;
        longint    side, sl, sr, l, r;
        t_out_item res;
        fl  = decode_word(it.front_left,  fmt);
        fr  = decode_word(it.front_right, fmt);
        ce  = decode_word(it.centre,      fmt);
        lfe = decode_word(it.low_freq,    fmt);
        bl  = decode_word(it.back_left,   fmt);
        br  = decode_word(it.back_right,  fmt);
        if (mix) begin
            if (fmt == FMT_U8) begin
                // 8-bit with mixing yields silence
                l = 0;
                r = 0;
            end else begin
                side = MIX_CENTRE_LFE * (ce + lfe);
                sl   = MIX_FRONT_BACK * (fl + bl) + side;
                sr   = MIX_FRONT_BACK * (fr + br) + side;
                if (fmt == FMT_F32) begin
                    l = (sl * FLT_FULL_SCALE) / FLT_MIX_DIV;
                    r = (sr * FLT_FULL_SCALE) / FLT_MIX_DIV;
                end else begin
                    l = sl / PCM_MIX_DIV;
                    r = sr / PCM_MIX_DIV;
                end
            end
        end else if (fmt == FMT_F32) begin
            l = (fl * FLT_FULL_SCALE) / Q23_UNIT;
            r = (fr * FLT_FULL_SCALE) / Q23_UNIT;
        end else begin
            l = fl;
            r = fr;
        end
        res.left_out  = l[15:0];
        res.right_out = r[15:0];
        return res;
    endfunction

    // Monitor: sample both channels at the rising edge. Pop before push, so a
    // frame accepted at this edge never matches a result leaving at it.
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (stereo_q.size() == 0) begin
                $error("result item with no frame pending: left %0d right %0d",
                       out_item.left_out, out_item.right_out);
                mismatches++;
            end else begin
                want = stereo_q.pop_front();
                if (out_item.left_out !== want.left_out) begin
                    $error("left_out: expected %0d, got %0d",
                           want.left_out, out_item.left_out);
                    mismatches++;
                end
                if (out_item.right_out !== want.right_out) begin
                    $error("right_out: expected %0d, got %0d",
                           want.right_out, out_item.right_out);
                    mismatches++;
                end
            end
        end
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            stereo_q.push_back(downmix_pair(in_item, mode_fmt, mode_mix));
    end

    // Source: hold an offered frame until taken, then advance or go idle.
    // The decision never looks at the stall, only at the last acceptance.
    always @(negedge clk) begin : source
        if (!in_valid || in_taken) begin
            if (rst_n && frames_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                in_item  <= frames_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Sink: random stalls, plus one long hold-off counted here.
    always @(negedge clk) begin : sink
        if (long_hold && hold_count < HOLD_CYCLES) begin
            hold_count++;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
        end
    end

    // Write one register; update the shadow once the write is taken.
    task automatic write_reg(input logic idx, input logic [1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SAMPLE_FORMAT)
            mode_fmt = t_fmt'(val);
        else
            mode_mix = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Set both registers; the unused upper bit of the mix write is random.
    task automatic set_mode(input t_fmt fmt, input logic mix);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        write_reg(CFG_SAMPLE_FORMAT, fmt);
        write_reg(CFG_MIX_ENABLE, {spare, mix});
    endtask

    task automatic push_frame(input logic [31:0] fl, input logic [31:0] fr,
                              input logic [31:0] ce, input logic [31:0] lfe,
                              input logic [31:0] bl, input logic [31:0] br);
        t_in_item it;
        it.front_left  = fl;
        it.front_right = fr;
        it.centre      = ce;
        it.low_freq    = lfe;
        it.back_left   = bl;
        it.back_right  = br;
        frames_q.push_back(it);
    endtask

    // Raw word: mostly fully random, some corners, some floats near unity.
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 11))
                    0:  w = 32'h0000_0000;
                    1:  w = 32'hFFFF_FFFF;
                    2:  w = 32'h0000_7FFF;
                    3:  w = 32'hFFFF_8000;
                    4:  w = 32'h007F_FFFF;
                    5:  w = 32'h0080_0000;
                    6:  w = 32'h0000_00FF;
                    7:  w = 32'h7F80_0000;
                    8:  w = 32'hFF80_0000;
                    9:  w = 32'h7FC0_0001;
                    10: w = 32'h3F80_0000;
                    default: w = 32'hBF80_0000;
                endcase
            end
            1, 2, 3: w = {1'($urandom_range(0, 1)), 8'($urandom_range(98, 130)),
                          23'($urandom)};
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic push_random_frame();
        logic [31:0] w;
        // now and then all six channels equal, to reach the sum extremes
        if ($urandom_range(0, 7) == 0) begin
            w = rand_word();
            push_frame(w, w, w, w, w, w);
        end else begin
            push_frame(rand_word(), rand_word(), rand_word(),
                       rand_word(), rand_word(), rand_word());
        end
    endtask

    // Wait until every frame is taken and every result has come, then settle.
    task automatic drain();
        while (frames_q.size() != 0 || in_valid || stereo_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int p;
        int n;
        int s;
        int idle_mode;

        // hold reset, then release it on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting, signed 16-bit copy: extremes and ignored upper bits.
        push_frame(32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_frame(32'h0000_7FFF, 32'h0000_8000, 32'h1234_5678, 32'h0, 32'h0, 32'h0);
        push_frame(32'hFFFF_7FFF, 32'h7FFF_8000, 32'h0, 32'h0, 32'h0, 32'h0);
        drain();

        // Signed 16-bit mix: full positive, full negative, opposite sides.
        set_mode(FMT_S16, 1'b1);
        push_frame(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF);
        push_frame(32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000, 32'h8000);
        push_frame(32'h7FFF, 32'h8000, 32'h0001, 32'hFFFF, 32'h7FFF, 32'h8000);
        drain();

        // Unsigned 8-bit copy, then 8-bit with mixing, which gives silence.
        set_mode(FMT_U8, 1'b0);
        push_frame(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'hABCD_EF80, 32'h0000_007F, 32'h0, 32'h0, 32'h0, 32'h0);
        drain();
        set_mode(FMT_U8, 1'b1);
        push_frame(32'hFF, 32'h00, 32'hFF, 32'h00, 32'hFF, 32'h00);
        drain();

        // Signed 24-bit: only bits 23..8 count.
        set_mode(FMT_S24, 1'b0);
        push_frame(32'h007F_FFFF, 32'h0080_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'hFF00_00FF, 32'h0000_FF00, 32'h0, 32'h0, 32'h0, 32'h0);
        drain();
        set_mode(FMT_S24, 1'b1);
        push_frame(32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000,
                   32'h0080_0000, 32'h0080_0000);
        drain();

        // Float copy: NaN, infinities, subnormal, tiny, unity, above unity,
        // smallest value that survives, negative zero.
        set_mode(FMT_F32, 1'b0);
        push_frame(32'h7FC0_0000, 32'h7F80_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'hFF80_0000, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'h3380_0000, 32'h3F80_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'hBF80_0000, 32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'h3F00_0000, 32'h3400_0000, 32'h0, 32'h0, 32'h0, 32'h0);
        push_frame(32'h8000_0000, 32'h3F7F_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
        drain();

        // Float mix: all plus one, all minus one, NaN mixed with values.
        set_mode(FMT_F32, 1'b1);
        push_frame(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
                   32'h3F80_0000, 32'h3F80_0000);
        push_frame(32'hFF80_0000, 32'hBF80_0000, 32'hBF80_0000, 32'hC000_0000,
                   32'hBF80_0000, 32'hFF80_0000);
        push_frame(32'h7FC0_0000, 32'h3F00_0000, 32'hFFFF_FFFF, 32'h3E80_0000,
                   32'h0000_0001, 32'hBF00_0000);
        drain();

        // Random phases: every mode twice, each time under a different idle pattern.
        for (p = 0; p < 16; p++) begin
            s         = p % 8;
            idle_mode = (p + p / 8) % 4;
            set_mode(t_fmt'(s >> 1), s[0]);
            case (idle_mode)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
                default: begin src_idle_pct = 30; snk_stall_pct = 30; end
            endcase
            for (n = 0; n < 32; n++)
                push_random_frame();
            drain();
        end

        // Long receiver hold-off while the sender keeps offering frames,
        // so the pipeline fills and stalls its input.
        set_mode(FMT_F32, 1'b1);
        src_idle_pct  = 0;
        snk_stall_pct = 20;
        long_hold     = 1'b1;
        for (n = 0; n < 60; n++)
            push_random_frame();
        drain();
        long_hold = 1'b0;

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
